@@ sv/hjrb_pkg.sv @@
// ----------------------------------------------------------------------------
// hjrb_pkg
// Shared types, codes and defaults for the joystick input report builder.
// ----------------------------------------------------------------------------
package hjrb_pkg;

    localparam int MAX_AXES_DEF    = 9;
    localparam int MAX_BUTTONS_DEF = 128;
    localparam int RAW_WIDTH_DEF   = 24;

    localparam int OP_W       = 2;
    localparam int SLOT_W     = 8;
    localparam int VALUE_W    = 24;
    localparam int BYTE_W     = 8;
    localparam int AXES_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SCALE_W    = 16;

    typedef logic [OP_W-1:0]      op_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam op_t OP_SET_AXIS   = 2'd0;
    localparam op_t OP_SET_BUTTON = 2'd1;
    localparam op_t OP_REPORT     = 2'd2;

    localparam cfg_idx_t CFG_AXES_IN_USE    = 3'd0;
    localparam cfg_idx_t CFG_BUTTONS_IN_USE = 3'd1;
    localparam cfg_idx_t CFG_AUTO_REPORT    = 3'd2;
    localparam cfg_idx_t CFG_REPORT_TAG     = 3'd3;
    localparam cfg_idx_t CFG_AXIS_LOW       = 3'd4;
    localparam cfg_idx_t CFG_AXIS_HIGH      = 3'd5;

    localparam logic [AXES_W-1:0]         AXES_RST    = 4'd1;
    localparam logic [SLOT_W-1:0]         BUTTONS_RST = 8'd1;
    localparam logic [BYTE_W-1:0]         TAG_RST     = 8'd3;
    localparam logic signed [VALUE_W-1:0] LOW_RST     = -24'sd1028;
    localparam logic signed [VALUE_W-1:0] HIGH_RST    = 24'sd1028;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BTN_MOD,
        ST_TAG,
        ST_BTN_OUT,
        ST_AX_GO,
        ST_AX_WAIT,
        ST_AX_LO,
        ST_AX_HI
    } state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_PREP,
        SC_DIV,
        SC_DONE
    } scl_state_t;

endpackage

@@ sv/hjrb_store.sv @@
// ----------------------------------------------------------------------------
// hjrb_store
// Synchronous memory, one write and one registered read per cycle; entries
// read as zero until first written after reset.
// ----------------------------------------------------------------------------
module hjrb_store
    import hjrb_pkg::*;
#(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_hit_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

@@ sv/hjrb_scaler.sv @@
// ----------------------------------------------------------------------------
// hjrb_scaler
// Clamp, mirror and map one raw axis value onto 0..65535 with a
// restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hjrb_scaler
    import hjrb_pkg::*;
#(
    parameter int RAW_WIDTH = RAW_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic signed [RAW_WIDTH-1:0] raw,
    input  logic signed [VALUE_W-1:0]   axis_low,
    input  logic signed [VALUE_W-1:0]   axis_high,
    output logic                        done,
    output logic [SCALE_W-1:0]          result
);

    localparam int CW    = (RAW_WIDTH > VALUE_W) ? RAW_WIDTH : VALUE_W;
    localparam int NUM_W = VALUE_W + SCALE_W;
    localparam int CNT_W = $clog2(SCALE_W);

    scl_state_t state_reg, state_next;

    logic [CNT_W-1:0]   cnt_reg;
    logic [VALUE_W-1:0] d_reg;
    logic [VALUE_W-1:0] den_reg;
    logic               zero_reg;
    logic [VALUE_W-1:0] rem_reg;
    logic [SCALE_W-1:0] quo_reg;

    logic signed [CW-1:0] v_ext, lo_ext, hi_ext, lo_min, hi_max, v_clamp;
    logic signed [CW-1:0] d_full, den_full;
    logic                 mirror;
    logic [NUM_W-1:0]     num;
    logic [VALUE_W:0]     trial;
    logic [VALUE_W:0]     diff;
    logic                 ge;

    always_comb
    begin
        v_ext   = CW'(raw);
        lo_ext  = CW'(axis_low);
        hi_ext  = CW'(axis_high);
        mirror  = lo_ext > hi_ext;
        lo_min  = mirror ? hi_ext : lo_ext;
        hi_max  = mirror ? lo_ext : hi_ext;
        if (v_ext < lo_min)
        begin
            v_clamp = lo_min;
        end
        else if (v_ext > hi_max)
        begin
            v_clamp = hi_max;
        end
        else
        begin
            v_clamp = v_ext;
        end
        d_full   = mirror ? (hi_max - v_clamp) : (v_clamp - lo_min);
        den_full = hi_max - lo_min;
    end

    assign num   = {d_reg, {SCALE_W{1'b0}}} - {{SCALE_W{1'b0}}, d_reg};
    assign trial = {rem_reg, quo_reg[SCALE_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SC_IDLE:
            begin
                if (go)
                begin
                    state_next = SC_PREP;
                end
            end
            SC_PREP: state_next = SC_DIV;
            SC_DIV:
            begin
                if (cnt_reg == CNT_W'(SCALE_W - 1))
                begin
                    state_next = SC_DONE;
                end
            end
            SC_DONE: state_next = SC_IDLE;
            default: state_next = SC_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == SC_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == SC_PREP)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == SC_DIV)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SC_IDLE && go)
        begin
            d_reg    <= d_full[VALUE_W-1:0];
            den_reg  <= den_full[VALUE_W-1:0];
            zero_reg <= (den_full[VALUE_W-1:0] == '0);
        end
        else if (state_reg == SC_PREP)
        begin
            rem_reg <= num[NUM_W-1:SCALE_W];
            quo_reg <= num[SCALE_W-1:0];
        end
        else if (state_reg == SC_DIV)
        begin
            rem_reg <= ge ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
            quo_reg <= {quo_reg[SCALE_W-2:0], ge};
        end
    end

    assign result = zero_reg ? '0 : quo_reg;

endmodule

@@ sv/hid_joystick_report_builder.sv @@
// ----------------------------------------------------------------------------
// hid_joystick_report_builder
// Axis and button state held in two small memories; streams input reports
// one byte per cycle, pausing while each axis is scaled by a bit-serial divider.
// ----------------------------------------------------------------------------
// Set axis: no report unless auto-report is on.
// Set button: memory read, then write back.
// Report: tag byte from the ST_TAG state through the output register, then
//   the button bytes, then two bytes per axis once the divider is done.
// One item at a time; busy is high while a button is modified or a report streams out.
// Reset: registers to defaults, all axes and buttons read as zero.
module hid_joystick_report_builder
    import hjrb_pkg::*;
#(
    parameter int MAX_AXES    = MAX_AXES_DEF,
    parameter int MAX_BUTTONS = MAX_BUTTONS_DEF,
    parameter int RAW_WIDTH   = RAW_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           op,
    input  logic [SLOT_W-1:0]         slot,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    output logic                      report_strobe,
    output logic [BYTE_W-1:0]         report_byte,
    output logic                      report_end
);

    localparam int BTN_DEPTH = (MAX_BUTTONS + 7) / 8;
    localparam int AADDR_W   = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    localparam int BADDR_W   = (BTN_DEPTH > 1) ? $clog2(BTN_DEPTH) : 1;

    state_t state_reg, state_next;

    logic [AXES_W-1:0]         axes_in_use_reg;
    logic [SLOT_W-1:0]         buttons_in_use_reg;
    logic                      auto_report_reg;
    logic [BYTE_W-1:0]         report_tag_reg;
    logic signed [VALUE_W-1:0] axis_low_reg;
    logic signed [VALUE_W-1:0] axis_high_reg;

    logic [SLOT_W-1:0]  slot_reg;
    logic               level_reg;
    logic [BADDR_W-1:0] btn_idx_reg;
    logic [AADDR_W-1:0] ax_idx_reg;
    logic               report_strobe_reg, report_strobe_next;
    logic [BYTE_W-1:0]  report_byte_reg, report_byte_next;
    logic               report_end_reg, report_end_next;

    logic               accept;
    logic [AXES_W-1:0]  na;
    logic [AXES_W-1:0]  na_m1;
    logic [SLOT_W-1:0]  nb;
    logic [SLOT_W-1:0]  nb_m1;
    logic               axis_hit;
    logic               btn_hit;
    logic               btn_last;
    logic               ax_last;
    logic [BYTE_W-1:0]  pad_mask;

    logic                 ax_we;
    logic [AADDR_W-1:0]   ax_waddr;
    logic [RAW_WIDTH-1:0] ax_wdata;
    logic [AADDR_W-1:0]   ax_raddr;
    logic [RAW_WIDTH-1:0] ax_rdata;

    logic               btn_we;
    logic [BADDR_W-1:0] btn_waddr;
    logic [BYTE_W-1:0]  btn_wdata;
    logic [BADDR_W-1:0] btn_raddr;
    logic [BYTE_W-1:0]  btn_rdata;
    logic [BYTE_W-1:0]  bit_sel;

    logic               scl_go;
    logic               scl_done;
    logic [SCALE_W-1:0] scl_result;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        if (axes_in_use_reg == '0)
        begin
            na = AXES_W'(1);
        end
        else if (axes_in_use_reg > AXES_W'(MAX_AXES))
        begin
            na = AXES_W'(MAX_AXES);
        end
        else
        begin
            na = axes_in_use_reg;
        end
        if (buttons_in_use_reg == '0)
        begin
            nb = SLOT_W'(1);
        end
        else if (buttons_in_use_reg > SLOT_W'(MAX_BUTTONS))
        begin
            nb = SLOT_W'(MAX_BUTTONS);
        end
        else
        begin
            nb = buttons_in_use_reg;
        end
        na_m1    = na - AXES_W'(1);
        nb_m1    = nb - SLOT_W'(1);
        axis_hit = slot < {{(SLOT_W - AXES_W){1'b0}}, na};
        btn_hit  = slot < nb;
        btn_last = (btn_idx_reg == nb_m1[3 +: BADDR_W]);
        ax_last  = (ax_idx_reg == na_m1[AADDR_W-1:0]);
        pad_mask = (nb[2:0] == 3'd0) ? {BYTE_W{1'b1}}
                                     : BYTE_W'((9'd1 << nb[2:0]) - 9'd1);
        bit_sel  = BYTE_W'(9'd1 << slot_reg[2:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_SET_AXIS:   state_next = auto_report_reg ? ST_TAG : ST_IDLE;
                        OP_SET_BUTTON: state_next = btn_hit ? ST_BTN_MOD : ST_IDLE;
                        OP_REPORT:     state_next = ST_TAG;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_BTN_MOD: state_next = auto_report_reg ? ST_TAG : ST_IDLE;
            ST_TAG:     state_next = ST_BTN_OUT;
            ST_BTN_OUT: state_next = btn_last ? ST_AX_GO : ST_BTN_OUT;
            ST_AX_GO:   state_next = ST_AX_WAIT;
            ST_AX_WAIT: state_next = scl_done ? ST_AX_LO : ST_AX_WAIT;
            ST_AX_LO:   state_next = ST_AX_HI;
            ST_AX_HI:   state_next = ax_last ? ST_IDLE : ST_AX_GO;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ax_we              = 1'b0;
        ax_waddr           = slot[AADDR_W-1:0];
        ax_wdata           = RAW_WIDTH'(value);
        ax_raddr           = '0;
        btn_we             = 1'b0;
        btn_waddr          = slot_reg[3 +: BADDR_W];
        btn_wdata          = level_reg ? (btn_rdata | bit_sel) : (btn_rdata & ~bit_sel);
        btn_raddr          = '0;
        scl_go             = 1'b0;
        report_strobe_next = 1'b0;
        report_byte_next   = '0;
        report_end_next    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ax_we     = accept && (op == OP_SET_AXIS) && axis_hit;
                btn_raddr = slot[3 +: BADDR_W];
            end
            ST_BTN_MOD:
            begin
                btn_we = 1'b1;
            end
            ST_TAG:
            begin
                report_strobe_next = 1'b1;
                report_byte_next   = report_tag_reg;
            end
            ST_BTN_OUT:
            begin
                btn_raddr          = btn_last ? '0 : btn_idx_reg + BADDR_W'(1);
                report_strobe_next = 1'b1;
                report_byte_next   = btn_last ? (btn_rdata & pad_mask) : btn_rdata;
            end
            ST_AX_GO:
            begin
                scl_go = 1'b1;
            end
            ST_AX_WAIT:
            begin
                ax_raddr = ax_idx_reg;
            end
            ST_AX_LO:
            begin
                report_strobe_next = 1'b1;
                report_byte_next   = scl_result[BYTE_W-1:0];
            end
            ST_AX_HI:
            begin
                ax_raddr           = ax_last ? '0 : ax_idx_reg + AADDR_W'(1);
                report_strobe_next = 1'b1;
                report_byte_next   = scl_result[SCALE_W-1:BYTE_W];
                report_end_next    = ax_last;
            end
            default:
            begin
                report_strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            axes_in_use_reg    <= AXES_RST;
            buttons_in_use_reg <= BUTTONS_RST;
            auto_report_reg    <= 1'b0;
            report_tag_reg     <= TAG_RST;
            axis_low_reg       <= LOW_RST;
            axis_high_reg      <= HIGH_RST;
            btn_idx_reg        <= '0;
            ax_idx_reg         <= '0;
            report_strobe_reg  <= 1'b0;
            report_end_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            report_strobe_reg <= report_strobe_next;
            report_end_reg    <= report_end_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_AXES_IN_USE:    axes_in_use_reg    <= cfg_data[AXES_W-1:0];
                    CFG_BUTTONS_IN_USE: buttons_in_use_reg <= cfg_data[SLOT_W-1:0];
                    CFG_AUTO_REPORT:    auto_report_reg    <= cfg_data[0];
                    CFG_REPORT_TAG:     report_tag_reg     <= cfg_data[BYTE_W-1:0];
                    CFG_AXIS_LOW:       axis_low_reg       <= cfg_data[VALUE_W-1:0];
                    CFG_AXIS_HIGH:      axis_high_reg      <= cfg_data[VALUE_W-1:0];
                    default:            auto_report_reg    <= auto_report_reg;
                endcase
            end
            if (state_reg == ST_TAG)
            begin
                btn_idx_reg <= '0;
            end
            else if (state_reg == ST_BTN_OUT)
            begin
                btn_idx_reg <= btn_idx_reg + BADDR_W'(1);
            end
            if (state_reg == ST_BTN_OUT)
            begin
                ax_idx_reg <= '0;
            end
            else if (state_reg == ST_AX_HI)
            begin
                ax_idx_reg <= ax_idx_reg + AADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg  <= slot;
            level_reg <= (value != '0);
        end
        report_byte_reg <= report_byte_next;
    end

    assign report_strobe = report_strobe_reg;
    assign report_byte   = report_byte_reg;
    assign report_end    = report_end_reg;

    hjrb_store #(
        .WIDTH  (RAW_WIDTH),
        .DEPTH  (MAX_AXES),
        .ADDR_W (AADDR_W)
    ) u_axis_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ax_we),
        .wr_addr (ax_waddr),
        .wr_data (ax_wdata),
        .rd_addr (ax_raddr),
        .rd_data (ax_rdata)
    );

    hjrb_store #(
        .WIDTH  (BYTE_W),
        .DEPTH  (BTN_DEPTH),
        .ADDR_W (BADDR_W)
    ) u_button_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (btn_we),
        .wr_addr (btn_waddr),
        .wr_data (btn_wdata),
        .rd_addr (btn_raddr),
        .rd_data (btn_rdata)
    );

    hjrb_scaler #(
        .RAW_WIDTH (RAW_WIDTH)
    ) u_scaler (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (scl_go),
        .raw       (ax_rdata),
        .axis_low  (axis_low_reg),
        .axis_high (axis_high_reg),
        .done      (scl_done),
        .result    (scl_result)
    );

endmodule

@@ tb/tb_hid_joystick_report_builder.sv @@
// ----------------------------------------------------------------------------
// tb_hid_joystick_report_builder
// Self-checking bench for the joystick input report builder. A queue-fed
// driver issues axis, button and report items with random sender gaps; a
// built-in predictor keeps its own axis and button state plus register
// copies and works out every report byte, and a monitor compares each
// strobed byte and end flag in order. Runs a directed pass over the
// corner cases, then random phases under several register settings.
// ----------------------------------------------------------------------------
module tb_hid_joystick_report_builder
    import hjrb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam op_t OP_UNUSED   = 2'd3;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  PHASE_ITEMS = 55;
    localparam int  PHASES      = 7;

    typedef struct {
        op_t                         code;
        logic [SLOT_W-1:0]           idx;
        logic signed [VALUE_W-1:0]   val;
    } joy_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } report_byte_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [OP_W-1:0]           op = OP_SET_AXIS;
    logic [SLOT_W-1:0]         slot = '0;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      report_strobe;
    logic [BYTE_W-1:0]         report_byte;
    logic                      report_end;

    hid_joystick_report_builder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .slot          (slot),
        .value         (value),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .report_strobe (report_strobe),
        .report_byte   (report_byte),
        .report_end    (report_end)
    );

    always #10 clk = ~clk;

    // register copies and joystick state
    logic [AXES_W-1:0]         cfg_axes    = AXES_RST;
    logic [SLOT_W-1:0]         cfg_buttons = BUTTONS_RST;
    logic                      cfg_auto    = 1'b0;
    logic [BYTE_W-1:0]         cfg_tag     = TAG_RST;
    logic signed [VALUE_W-1:0] cfg_low     = LOW_RST;
    logic signed [VALUE_W-1:0] cfg_high    = HIGH_RST;

    logic signed [VALUE_W-1:0] axis_mem [MAX_AXES_DEF];
    logic [7:0]                button_mem [(MAX_BUTTONS_DEF + 7) / 8];

    joy_item_t    pending_items [$];
    report_byte_t expected_bytes [$];

    int  items_pushed = 0;
    int  items_taken  = 0;
    int  mismatches   = 0;
    int  cycles       = 0;
    int  gap_left     = 0;
    bit  idle_enabled = 1'b0;

    initial
    begin
        foreach (axis_mem[i])
            axis_mem[i] = '0;
        foreach (button_mem[i])
            button_mem[i] = '0;
    end

    function automatic int axis_count();
        if (cfg_axes == 0)
            return 1;
        if (cfg_axes > MAX_AXES_DEF)
            return MAX_AXES_DEF;
        return int'(cfg_axes);
    endfunction

    function automatic int button_count();
        if (cfg_buttons == 0)
            return 1;
        if (cfg_buttons > MAX_BUTTONS_DEF)
            return MAX_BUTTONS_DEF;
        return int'(cfg_buttons);
    endfunction

    function automatic logic [15:0] scaled_axis(logic signed [VALUE_W-1:0] raw);
        longint a;
        longint b;
        longint lo;
        longint hi;
        longint v;
        a  = cfg_low;
        b  = cfg_high;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        v  = raw;
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        if (a > b)
            v = hi - v + lo;
        if (hi == lo)
            return 16'd0;
        return 16'(((v - lo) * 65535) / (hi - lo));
    endfunction

    function automatic void push_report_byte(logic [7:0] data, logic last);
        report_byte_t rb;
        rb.data = data;
        rb.last = last;
        expected_bytes.push_back(rb);
    endfunction

    function automatic void predict_report();
        int         nb;
        int         nbytes;
        int         na;
        int         used;
        logic [7:0] bits;
        logic [15:0] s;
        nb     = button_count();
        nbytes = (nb + 7) / 8;
        na     = axis_count();
        push_report_byte(cfg_tag, 1'b0);
        for (int i = 0; i < nbytes; i++)
        begin
            bits = button_mem[i];
            used = nb - i * 8;
            if (used < 8)
                bits = bits & 8'((1 << used) - 1);
            push_report_byte(bits, 1'b0);
        end
        for (int i = 0; i < na; i++)
        begin
            s = scaled_axis(axis_mem[i]);
            push_report_byte(s[7:0], 1'b0);
            push_report_byte(s[15:8], i == na - 1);
        end
    endfunction

    function automatic void predict_item(op_t code, logic [SLOT_W-1:0] idx,
                                         logic signed [VALUE_W-1:0] val);
        case (code)
            OP_SET_AXIS:
            begin
                if (idx < axis_count())
                    axis_mem[idx] = val;
                if (cfg_auto)
                    predict_report();
            end
            OP_SET_BUTTON:
            begin
                if (idx < button_count())
                begin
                    button_mem[idx / 8][idx % 8] = (val != 0);
                    if (cfg_auto)
                        predict_report();
                end
            end
            OP_REPORT:
                predict_report();
            default:
            begin
            end
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        joy_item_t it;
        if (!rst_n)
        begin
            start    <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_item(op, slot, value);
                items_taken++;
            end
            if (start && busy)
            begin
                // hold the item until taken
            end
            else if (gap_left != 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() != 0 && idle_enabled && $urandom_range(0, 3) == 0)
            begin
                start    <= 1'b0;
                gap_left <= $urandom_range(1, 10) - 1;
            end
            else if (pending_items.size() != 0)
            begin
                it    = pending_items.pop_front();
                start <= 1'b1;
                op    <= it.code;
                slot  <= it.idx;
                value <= it.val;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        report_byte_t want;
        if (rst_n && report_strobe)
        begin
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report byte %02h end %0b", report_byte, report_end);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (want.data !== report_byte || want.last !== report_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report byte mismatch: expected %02h end %0b, got %02h end %0b",
                                 want.data, want.last, report_byte, report_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_item(op_t code, int idx, int val);
        joy_item_t it;
        it.code = code;
        it.idx  = SLOT_W'(idx);
        it.val  = VALUE_W'(val);
        pending_items.push_back(it);
        items_pushed++;
    endtask

    task automatic wait_idle();
        while (items_taken != items_pushed || busy || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_AXES_IN_USE:    cfg_axes    = data[AXES_W-1:0];
            CFG_BUTTONS_IN_USE: cfg_buttons = data[SLOT_W-1:0];
            CFG_AUTO_REPORT:    cfg_auto    = data[0];
            CFG_REPORT_TAG:     cfg_tag     = data[BYTE_W-1:0];
            CFG_AXIS_LOW:       cfg_low     = data;
            CFG_AXIS_HIGH:      cfg_high    = data;
            default:
            begin
            end
        endcase
    endtask

    task automatic configure(int axes, int buttons, int auto_on, int tag, int low, int high);
        wait_idle();
        write_reg(CFG_AXES_IN_USE, CFG_DATA_W'(axes));
        write_reg(CFG_BUTTONS_IN_USE, CFG_DATA_W'(buttons));
        write_reg(CFG_AUTO_REPORT, CFG_DATA_W'(auto_on));
        write_reg(CFG_REPORT_TAG, CFG_DATA_W'(tag));
        write_reg(CFG_AXIS_LOW, CFG_DATA_W'(low));
        write_reg(CFG_AXIS_HIGH, CFG_DATA_W'(high));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic add_random_item(output bit counted);
        int     r;
        int     idx;
        int     val;
        longint lo;
        longint hi;
        r   = $urandom_range(0, 19);
        lo  = (cfg_low < cfg_high) ? longint'(cfg_low) : longint'(cfg_high);
        hi  = (cfg_low < cfg_high) ? longint'(cfg_high) : longint'(cfg_low);
        val = $urandom;
        counted = 1'b1;
        if (r < 8)
        begin
            idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, axis_count());
            case ($urandom_range(0, 4))
                0: val = $urandom;
                1: val = int'(lo + longint'($urandom_range(0, int'(hi - lo))));
                2: val = int'(lo) + $urandom_range(0, 2) - 1;
                3: val = int'(hi) + $urandom_range(0, 2) - 1;
                default: val = $urandom_range(0, 600) - 300;
            endcase
            add_item(OP_SET_AXIS, idx, val);
        end
        else if (r < 15)
        begin
            idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, button_count());
            if ($urandom_range(0, 1) == 0)
                val = 0;
            add_item(OP_SET_BUTTON, idx, val);
        end
        else if (r < 19)
        begin
            add_item(OP_REPORT, $urandom_range(0, 255), val);
        end
        else
        begin
            add_item(OP_UNUSED, $urandom_range(0, 255), val);
            counted = 1'b0;
        end
    endtask

    initial
    begin
        bit counted;
        int n;
        int center;
        int low;
        int high;
        int axes;
        int buttons;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // defaults after reset
        add_item(OP_REPORT, 0, 0);
        add_item(OP_SET_AXIS, 0, 8388607);
        add_item(OP_REPORT, 255, -1);
        add_item(OP_SET_AXIS, 0, -8388608);
        add_item(OP_SET_BUTTON, 0, 1);
        add_item(OP_REPORT, 0, 0);
        add_item(OP_SET_BUTTON, 1, 1);
        add_item(OP_UNUSED, 255, -1);
        add_item(OP_SET_AXIS, 1, 5);
        add_item(OP_REPORT, 0, 0);

        // counts above range, auto report, reversed extreme range
        configure(15, 255, 1, 255, 8388607, -8388608);
        add_item(OP_SET_AXIS, 8, 8388607);
        add_item(OP_SET_AXIS, 9, 100);
        add_item(OP_SET_BUTTON, 127, -8388608);
        add_item(OP_SET_BUTTON, 128, 1);
        add_item(OP_SET_BUTTON, 0, 0);
        add_item(OP_UNUSED, 0, 0);

        // zero counts, empty range
        configure(0, 0, 0, 0, 0, 0);
        add_item(OP_SET_AXIS, 0, 123);
        add_item(OP_REPORT, 0, 0);
        add_item(OP_SET_BUTTON, 0, 1);
        add_item(OP_REPORT, 0, 0);

        // padding in the last button byte
        configure(2, 9, 0, 8'h5a, -1028, 1028);
        add_item(OP_SET_BUTTON, 8, 1);
        add_item(OP_SET_BUTTON, 9, 1);
        add_item(OP_SET_BUTTON, 7, 1);
        add_item(OP_SET_AXIS, 1, -1028);
        add_item(OP_REPORT, 0, 0);

        for (int p = 0; p < PHASES; p++)
        begin
            axes    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 9);
            buttons = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 40);
            center  = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000) - 2000;
            case ($urandom_range(0, 4))
                0:
                begin
                    low  = $urandom;
                    high = $urandom;
                end
                1:
                begin
                    low  = center;
                    high = center + $urandom_range(1, 2000);
                end
                2:
                begin
                    low  = center;
                    high = center;
                end
                3:
                begin
                    low  = center + $urandom_range(1, 2000);
                    high = center;
                end
                default:
                begin
                    low  = -8388608;
                    high = 8388607;
                end
            endcase
            configure(axes, buttons, $urandom_range(0, 1), $urandom_range(0, 255), low, high);
            idle_enabled = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                add_random_item(counted);
                if (counted)
                    n++;
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ hid_joystick_report_builder.f @@
sv/hjrb_pkg.sv
sv/hjrb_store.sv
sv/hjrb_scaler.sv
sv/hid_joystick_report_builder.sv
tb/tb_hid_joystick_report_builder.sv
